>>> rtl/core/tcd_pkg.sv
// tcd_pkg: shared constants for the tilt change key detector
// angle formats, key codes, register indexes and the arctangent table
// no dependencies
package tcd_pkg;

  // angle format: 1/128 degree per lsb
  localparam int ANGLE_W        = 16;
  localparam int THR_W          = 17;
  localparam int FRAC_SHIFT     = 8;
  localparam int PRESCALE_SHIFT = 24;
  // accumulator: 1/32768 degree per lsb, covers +-360 degrees
  localparam int ACC_W          = 25;

  localparam logic signed [THR_W-1:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [THR_W-1:0] QUARTER_TURN = 17'sd11520;
  localparam logic signed [ACC_W-1:0] HALF_TURN_SCALED = 25'sd5898240;

  // key codes
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_UP   = 2'd1;
  localparam logic [1:0] KEY_DOWN = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DN_THRESH = 2'd2;

  localparam logic signed [THR_W-1:0] UP_THRESH_RST = 17'sd1024;
  localparam logic signed [THR_W-1:0] DN_THRESH_RST = -17'sd1024;

  // atan(2^-i) in degrees scaled by 32768, rounded
  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = 5;
  localparam int TAB_W     = 21;
  localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
    21'd1474560, 21'd870484, 21'd459940, 21'd233473,
    21'd117189,  21'd58653,  21'd29333,  21'd14667,
    21'd7334,    21'd3667,   21'd1833,   21'd917,
    21'd458,     21'd229,    21'd115,    21'd57,
    21'd29,      21'd14,     21'd7,      21'd4,
    21'd2,       21'd1,      21'd0,      21'd0
  };

endpackage

>>> rtl/core/tcd_cordic.sv
// tcd_cordic: iterative vectoring cordic giving atan2(y, z) in 1/128 degree
// one shared add/shift datapath, one micro-rotation per cycle
// depends on tcd_pkg
module tcd_cordic #(
  parameter int SAMPLE_BITS      = 12,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       y_i,
  input  logic signed [SAMPLE_BITS-1:0]       z_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic signed [tcd_pkg::ANGLE_W-1:0]  angle_o
);

  // datapath width: prescaled sample plus headroom for cordic gain and negation
  localparam int W    = SAMPLE_BITS + tcd_pkg::PRESCALE_SHIFT + 3;
  localparam int CNTW = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;
  localparam int RW   = tcd_pkg::ACC_W - tcd_pkg::FRAC_SHIFT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ITER = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [CNTW-1:0]                   cnt_q, cnt_d;
  logic signed [W-1:0]               x_q, x_d;
  logic signed [W-1:0]               y_q, y_d;
  logic signed [tcd_pkg::ACC_W-1:0]  acc_q, acc_d;

  logic signed [W-1:0]               y_ext, z_ext, y_pre, z_pre, xs, ys;
  logic signed [tcd_pkg::ACC_W-1:0]  tab_val, acc_rnd;
  logic signed [RW-1:0]              ang_r;
  logic signed [tcd_pkg::THR_W-1:0]  ang_c;

  assign y_ext = W'(y_i);
  assign z_ext = W'(z_i);
  assign y_pre = y_ext <<< tcd_pkg::PRESCALE_SHIFT;
  assign z_pre = z_ext <<< tcd_pkg::PRESCALE_SHIFT;

  // shared micro-rotation operands
  assign xs      = x_q >>> cnt_q;
  assign ys      = y_q >>> cnt_q;
  assign tab_val = tcd_pkg::ACC_W'(
                     tcd_pkg::ATAN_TAB[tcd_pkg::TAB_IDX_W'(cnt_q)]);

  // sequencer and datapath next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          priority if (y_i == '0) begin
            // on the z axis: 0 or half turn
            acc_d   = (z_i < 0) ? tcd_pkg::HALF_TURN_SCALED : '0;
            state_d = ST_DONE;
          end else if (z_i == '0) begin
            // on the y axis: plus or minus quarter turn
            acc_d   = (y_i > 0) ? (tcd_pkg::ACC_W'(tcd_pkg::QUARTER_TURN)
                                   <<< tcd_pkg::FRAC_SHIFT)
                                : -(tcd_pkg::ACC_W'(tcd_pkg::QUARTER_TURN)
                                   <<< tcd_pkg::FRAC_SHIFT);
            state_d = ST_DONE;
          end else if (z_i < 0) begin
            // fold into the right half plane
            x_d     = -z_pre;
            y_d     = -y_pre;
            acc_d   = (y_i >= 0) ? tcd_pkg::HALF_TURN_SCALED
                                 : -tcd_pkg::HALF_TURN_SCALED;
            state_d = ST_ITER;
          end else begin
            x_d     = z_pre;
            y_d     = y_pre;
            acc_d   = '0;
            state_d = ST_ITER;
          end
        end
      end
      ST_ITER: begin
        if (y_q > 0) begin
          x_d   = x_q + ys;
          y_d   = y_q - xs;
          acc_d = acc_q + tab_val;
        end else begin
          x_d   = x_q - ys;
          y_d   = y_q + xs;
          acc_d = acc_q - tab_val;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNTW'(ANGLE_ITERATIONS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  // round half up to 1/128 degree and clamp to a half turn
  assign acc_rnd = acc_q + tcd_pkg::ACC_W'(1 << (tcd_pkg::FRAC_SHIFT - 1));
  assign ang_r   = RW'(acc_rnd >>> tcd_pkg::FRAC_SHIFT);

  always_comb begin
    priority if (ang_r > tcd_pkg::HALF_TURN) begin
      ang_c = tcd_pkg::HALF_TURN;
    end else if (ang_r < -tcd_pkg::HALF_TURN) begin
      ang_c = -tcd_pkg::HALF_TURN;
    end else begin
      ang_c = ang_r;
    end
  end

  assign angle_o     = tcd_pkg::ANGLE_W'(ang_c);
  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

endmodule

>>> rtl/core/tilt_change_key_detector.sv
// tilt_change_key_detector: tilt angle from y/z acceleration and up/down key events
// depends on tcd_pkg and tcd_cordic
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one signed y/z sample pair per
//   transaction. Output channel (out_valid_o/out_ready_i) returns one transaction
//   per sample: key_o (none, up, down) and tilt_angle_o in 1/128 degree.
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at the
//   clock edge: index 0 enable, 1 up threshold, 2 down threshold, others ignored.
//   A general sample passes through the micro-rotations; a sample with a zero axis
//   reading skips them. A new sample is accepted only when the cordic is idle,
//   as the single cordic datapath does one micro-rotation per cycle and holds
//   one sample at a time.
//   The result sits in an output register, so a new sample is accepted while a
//   finished result waits. If the receiver stalls, the next result waits in the
//   cordic and in_ready_o stays low until the output register frees.
//   Reset: enable off, thresholds +8 and -8 degrees, reference angle zero,
//   no result pending.
module tilt_change_key_detector #(
  parameter int SAMPLE_BITS      = 12,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]         accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0]         accel_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            key_o,
  output logic signed [tcd_pkg::ANGLE_W-1:0]    tilt_angle_o,
  input  logic                                  cfg_we_i,
  input  logic [tcd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tcd_pkg::THR_W-1:0]             cfg_wdata_i
);

  logic                                 enable_q;
  logic signed [tcd_pkg::THR_W-1:0]     up_thr_q, dn_thr_q;
  logic signed [tcd_pkg::ANGLE_W-1:0]   ref_q, ref_d;
  logic                                 out_valid_q, out_valid_d;
  logic [1:0]                           key_q, key_d;
  logic signed [tcd_pkg::ANGLE_W-1:0]   angle_q;

  logic                                 res_valid, res_ready, res_take;
  logic signed [tcd_pkg::ANGLE_W-1:0]   res_angle;
  logic signed [tcd_pkg::THR_W-1:0]     diff;

  // angle unit
  tcd_cordic #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .y_i         (accel_y_i),
    .z_i         (accel_z_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .angle_o     (res_angle)
  );

  assign res_ready = !out_valid_q || out_ready_i;
  assign res_take  = res_valid && res_ready;

  // key decision against the reference angle, no wrap
  assign diff = tcd_pkg::THR_W'(ref_q) - tcd_pkg::THR_W'(res_angle);

  always_comb begin
    key_d = tcd_pkg::KEY_NONE;
    ref_d = ref_q;
    if (enable_q) begin
      priority if (diff > up_thr_q) begin
        key_d = tcd_pkg::KEY_UP;
        ref_d = res_angle;
      end else if (diff < dn_thr_q) begin
        key_d = tcd_pkg::KEY_DOWN;
        ref_d = res_angle;
      end else begin
        key_d = tcd_pkg::KEY_NONE;
      end
    end
  end

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state, configuration and reference
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      up_thr_q    <= tcd_pkg::UP_THRESH_RST;
      dn_thr_q    <= tcd_pkg::DN_THRESH_RST;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (res_take) begin
        ref_q <= ref_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tcd_pkg::CFG_ENABLE:    enable_q <= cfg_wdata_i[0];
          tcd_pkg::CFG_UP_THRESH: up_thr_q <= cfg_wdata_i;
          tcd_pkg::CFG_DN_THRESH: dn_thr_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      key_q   <= key_d;
      angle_q <= res_angle;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_o        = key_q;
  assign tilt_angle_o = angle_q;

endmodule
